/* hdl/cl2n_pkg.sv */
// ----------------------------------------------------------------------------
// cl2n_pkg
// shared constants for the per-channel l2 normalisation block
// ----------------------------------------------------------------------------
package cl2n_pkg;

  localparam int CFG_BITS = 7;
  localparam int OUT_BITS = 16;
  localparam int Q15_FRAC = 15;
  localparam logic [OUT_BITS-1:0] Q15_MAX = 16'h7fff;

endpackage

/* hdl/channel_l2_normalize.sv */
// ----------------------------------------------------------------------------
// channel_l2_normalize
// per-channel l2 normalisation: stores samples, sums squares, takes the
// floor square root and emits each sample divided by it as q1.15
// ----------------------------------------------------------------------------
// loading: one sample per cycle while s_tready is high, square added in a one-stage pipeline
// end of channel: the sum settles, then the bit-pair square root is taken
// each result: one memory read, a restoring divide, then the result is
// presented and held until the handshake
// no input is taken while a channel is rooted or drained
// synchronous reset clears control, sums and length register (64); store undefined
module channel_l2_normalize #(
  parameter int MAX_CHANNEL_SAMPLES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cl2n_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // normalized
  output logic                          m_tlast,   // last_of_channel
  output logic                          m_tuser    // zero_channel
);
  import cl2n_pkg::*;

  localparam int AW = (MAX_CHANNEL_SAMPLES > 1) ? $clog2(MAX_CHANNEL_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_CHANNEL_SAMPLES + 1);
  localparam int SUMW = 2 * SAMPLE_BITS + 6;
  localparam int RW = SAMPLE_BITS + 3;
  localparam int NW = SAMPLE_BITS + Q15_FRAC;   // dividend width
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int SQ_STEPS = SUMW / 2;
  localparam int DIV_STEPS = NW;
  localparam int STW = $clog2(NW + 1);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [CFG_BITS-1:0] pixels_per_channel;
  logic [SAMPLE_BITS-1:0] sample_store [MAX_CHANNEL_SAMPLES];
  logic [SUMW-1:0] square_sum;
  logic [CW-1:0] fill_count;
  logic [RW-1:0] norm_root;
  logic [SAMPLE_BITS-1:0] rd_data;

  // square pipeline
  logic sq_vld;
  logic [SQW-1:0] sq_val;
  logic sq_end;

  // root unit (bit-pair restoring)
  logic [SUMW-1:0] rt_rem;
  logic [SUMW-1:0] rt_res;
  logic [SUMW-1:0] rt_bit;
  logic [STW-1:0] step;

  // divider
  logic [NW-1:0] dv_num;
  logic [RW:0] dv_rem;
  logic dv_neg;
  logic [CW-1:0] rd_idx;

  logic [CW-1:0] len;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] mag;
  logic [CW-1:0] fill_eff;
  logic [CW-1:0] fill_inc;
  logic take;

  always_comb begin
    if (pixels_per_channel == '0) len = CW'(1);
    else if (32'(pixels_per_channel) > MAX_CHANNEL_SAMPLES)
      len = CW'(MAX_CHANNEL_SAMPLES);
    else len = CW'(pixels_per_channel);
  end

  assign smp = s_tdata[SAMPLE_BITS-1:0];
  assign mag = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
  assign fill_eff = (fill_count >= CW'(MAX_CHANNEL_SAMPLES)) ?
                    CW'(MAX_CHANNEL_SAMPLES - 1) : fill_count;
  assign fill_inc = fill_eff + 1'b1;
  assign s_tready = (state == ST_LOAD) && !sq_end;
  assign take = s_tvalid && s_tready;

  logic [SUMW-1:0] rt_trial;
  assign rt_trial = rt_res + rt_bit;

  logic [RW:0] dv_shift;
  assign dv_shift = {dv_rem[RW-1:0], dv_num[NW-1]};
  logic dv_ge;
  assign dv_ge = dv_shift >= {1'b0, norm_root};

  always_ff @(posedge clk) begin
    if (take) sample_store[fill_eff[AW-1:0]] <= smp;
    rd_data <= sample_store[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      pixels_per_channel <= CFG_BITS'(64);
      square_sum <= '0;
      fill_count <= '0;
      norm_root <= '0;
      sq_vld <= 1'b0;
      sq_end <= 1'b0;
      m_tvalid <= 1'b0;
      rd_idx <= '0;
      step <= '0;
    end else begin
      if (cfg_we) pixels_per_channel <= cfg_wdata;
      sq_vld <= take;
      sq_val <= SQW'(mag) * SQW'(mag);
      if (sq_vld) square_sum <= square_sum + SUMW'(sq_val);
      case (state)
        ST_LOAD: begin
          if (take) begin
            fill_count <= fill_inc;
            if (fill_inc >= len) sq_end <= 1'b1;
          end
          if (sq_end && !sq_vld) begin
            sq_end <= 1'b0;
            rt_rem <= square_sum;
            rt_res <= '0;
            rt_bit <= SUMW'(1) << (2 * SQ_STEPS - 2);
            step <= '0;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (rt_rem >= rt_trial) begin
            rt_rem <= rt_rem - rt_trial;
            rt_res <= (rt_res >> 1) + rt_bit;
          end else begin
            rt_res <= rt_res >> 1;
          end
          rt_bit <= rt_bit >> 2;
          step <= step + 1'b1;
          if (step == STW'(SQ_STEPS - 1)) begin
            rd_idx <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (step == STW'(SQ_STEPS)) begin
            // first entry after root: capture final root
            norm_root <= RW'(rt_res);
          end
          step <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == '0) begin
            dv_neg <= rd_data[SAMPLE_BITS-1];
            dv_num <= {(rd_data[SAMPLE_BITS-1] ? (~rd_data + 1'b1) : rd_data),
                       {Q15_FRAC{1'b0}}};
            dv_rem <= '0;
            step <= STW'(1);
          end else begin
            dv_rem <= dv_ge ? (dv_shift - {1'b0, norm_root}) : dv_shift;
            dv_num <= {dv_num[NW-2:0], dv_ge};
            step <= step + 1'b1;
            if (step == STW'(DIV_STEPS)) state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tuser <= (norm_root == '0);
            m_tlast <= (rd_idx + 1'b1 == fill_count);
            if (norm_root == '0) m_tdata <= '0;
            else if (dv_num > NW'(Q15_MAX))
              m_tdata <= dv_neg ? (~Q15_MAX + 1'b1) : Q15_MAX;
            else
              m_tdata <= dv_neg ? (~dv_num[OUT_BITS-1:0] + 1'b1) : dv_num[OUT_BITS-1:0];
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              fill_count <= '0;
              square_sum <= '0;
              state <= ST_LOAD;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// channel_l2_normalize testbench
// drives channels of signed samples through the stream slave, predicts each
// channel's normalised q1.15 results and checks them against the master side
// ----------------------------------------------------------------------------
class l2_norm_scoreboard;

  typedef struct {
    logic [15:0] normalized;
    bit          last_of_channel;
    bit          zero_channel;
  } norm_result_t;

  norm_result_t           expected_q[$];
  int                     held[64];
  int                     held_count;
  longint unsigned        square_sum;
  int                     length_reg;
  int                     errors;
  int                     results_seen;
  int                     channels_done;
  int                     zero_channels;
  int                     saturations;

  function new();
    length_reg = 64;
  endfunction

  function void write_length(int value);
    length_reg = value & 8'h7f;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function longint unsigned root_of(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function logic [15:0] scale_q15(int x, longint unsigned root);
    longint unsigned mag;
    longint unsigned q;
    int              s;
    mag = (x < 0) ? -x : x;
    q = (mag << 15) / root;
    if (q > 32767) begin
      q = 32767;
      saturations++;
    end
    s = (x < 0) ? -int'(q) : int'(q);
    return s[15:0];
  endfunction

  // accepted input transaction: store, accumulate, emit on channel end
  function void note_sample(logic signed [15:0] sample);
    int              chan_len;
    longint unsigned root;
    int              mag;
    norm_result_t    r;
    chan_len = length_reg;
    if (chan_len == 0) chan_len = 1;
    if (chan_len > 64) chan_len = 64;
    if (held_count >= 64) held_count = 63;
    held[held_count] = sample;
    mag = (sample < 0) ? -int'(sample) : int'(sample);
    square_sum += longint'(mag) * longint'(mag);
    held_count++;
    if (held_count < chan_len) return;
    root = root_of(square_sum);
    for (int k = 0; k < held_count; k++) begin
      r.zero_channel = (root == 0);
      r.normalized = (root == 0) ? 16'd0 : scale_q15(held[k], root);
      r.last_of_channel = (k + 1 == held_count);
      expected_q.push_back(r);
    end
    channels_done++;
    if (root == 0) zero_channels++;
    held_count = 0;
    square_sum = 0;
  endfunction

  function void check_result(logic [15:0] normalized, logic last, logic zero);
    norm_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result normalized=%h last=%b zero=%b",
               $time, normalized, last, zero);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (normalized !== e.normalized) begin
      $display("%0t: normalized expected %h actual %h", $time, e.normalized, normalized);
      errors++;
    end
    if (last !== e.last_of_channel) begin
      $display("%0t: tlast expected %b actual %b", $time, e.last_of_channel, last);
      errors++;
    end
    if (zero !== e.zero_channel) begin
      $display("%0t: tuser expected %b actual %b", $time, e.zero_channel, zero);
      errors++;
    end
  endfunction

endclass

module testbench;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // normalized
  logic        m_tlast;   // last_of_channel
  logic        m_tuser;   // zero_channel

  l2_norm_scoreboard norm_sb;
  bit                quiet;
  int                samples_sent;

  channel_l2_normalize dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("channel_l2_normalize test failed");
    $finish;
  end

  // output stall bursts
  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) norm_sb.check_result(m_tdata, m_tlast, m_tuser);
  end

  task automatic send_sample(logic signed [15:0] x);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= x;
    do @(posedge clk); while (!s_tready);
    norm_sb.note_sample(x);
    samples_sent++;
  endtask

  // register writes only once all expected results are out and the core has settled
  task automatic set_length(int value);
    s_tvalid <= 0;
    @(posedge clk);
    while (norm_sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value[6:0];
    @(posedge clk);
    cfg_we <= 0;
    norm_sb.write_length(value);
  endtask

  function automatic logic signed [15:0] pick_sample(int flavour);
    case (flavour)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      2: return 16'sd0;
      default: return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    int lengths[9];
    int chan_len;
    int flavour;
    int cut;
    lengths = '{1, 2, 3, 7, 16, 33, 64, 0, 127};
    norm_sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = 0;
    quiet = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes in a short channel
    set_length(4);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(16'sd1);
    // all-zero channel
    repeat (4) send_sample(16'sd0);
    // zero length behaves as one; lone full-scale sample saturates
    set_length(0);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(16'sd100);
    // shrink the length while a channel is part filled
    set_length(8);
    repeat (5) send_sample(pick_sample(0));
    set_length(3);
    send_sample(pick_sample(0));
    // oversize length clamps to the store depth
    set_length(127);
    repeat (64) send_sample(pick_sample(3));

    while (samples_sent < 330) begin
      if (samples_sent > 270) quiet = 1;
      if ($urandom_range(0, 2) == 0) begin
        chan_len = lengths[$urandom_range(0, 8)];
        if (chan_len > 16 && $urandom_range(0, 2) != 0) chan_len = $urandom_range(1, 12);
        set_length(chan_len);
      end
      chan_len = norm_sb.length_reg;
      if (chan_len == 0) chan_len = 1;
      if (chan_len > 64) chan_len = 64;
      flavour = $urandom_range(0, 9);
      flavour = (flavour < 5) ? 0 : (flavour < 7) ? 1 : (flavour == 7) ? 2 : 3;
      if (chan_len > 2 && $urandom_range(0, 7) == 0) begin
        // broken sequence: part of a channel, then a shorter length
        cut = $urandom_range(1, chan_len - 1);
        repeat (cut) send_sample(pick_sample(flavour));
        set_length($urandom_range(1, cut));
        send_sample(pick_sample(flavour));
      end else begin
        repeat (chan_len) send_sample(pick_sample(flavour));
      end
    end
    s_tvalid <= 0;

    while (norm_sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d samples, %0d channels closed (%0d all zero), %0d results checked",
             samples_sent, norm_sb.channels_done, norm_sb.zero_channels,
             norm_sb.results_seen);
    $display("saturated quotients predicted: %0d", norm_sb.saturations);
    if (norm_sb.errors == 0 && norm_sb.pending() == 0) begin
      $display("channel_l2_normalize test passed");
    end else begin
      $display("channel_l2_normalize test failed");
    end
    $finish;
  end

endmodule
